// ----- hdl/egm_pkg.sv -----
`default_nettype none
package egm_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 13;
  localparam int WREG_W = 11;
  localparam int HREG_W = 13;
  localparam int ACC_W = 11;
  localparam int SQ_W = 20;
  localparam int SUM_W = 21;
  localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       take_pixel;
    logic       count_item;
    logic       clr_acc;
    logic       rd_en;
    logic [3:0] tap;
    logic       square;
    logic       sum;
    logic       root_step;
    logic [2:0] root_bit;
    logic       round;
    logic       load_out;
  } egm_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic all_in;
    logic emit_ok;
    logic out_free;
  } egm_stat_t;

  // Row offset of a window tap, taps numbered in raster order 0..8.
  function automatic logic signed [1:0] tap_dr(input logic [3:0] k);
    logic signed [1:0] r;
    begin
      if (k < 4'd3) r = -2'sd1;
      else if (k < 4'd6) r = 2'sd0;
      else r = 2'sd1;
      return r;
    end
  endfunction

  // Column offset of a window tap.
  function automatic logic signed [1:0] tap_dc(input logic [3:0] k);
    logic signed [1:0] r;
    begin
      if (k == 4'd0 || k == 4'd3 || k == 4'd6) r = -2'sd1;
      else if (k == 4'd1 || k == 4'd4 || k == 4'd7) r = 2'sd0;
      else r = 2'sd1;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/egm_ctrl.sv -----
`default_nettype none
module egm_ctrl
  import egm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  input  wire logic      s_tuser,
  output logic           s_tready,
  input  wire egm_stat_t stat,
  output egm_cmd_t       cmd
);

  typedef enum logic [2:0] {
    IDLE, READ, ACC, SQR, SUM, ROOT, RND, DONE
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [3:0] tap;
  logic [2:0] bit_idx;

  assign s_tready = (state == IDLE);

  // Command decode and next state.
  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.tap = tap;
    cmd.root_bit = bit_idx;
    unique case (state)
      IDLE: begin
        if (s_tvalid && !(s_tuser && !stat.all_in)) begin
          cmd.take_pixel = !s_tuser && !stat.all_in;
          cmd.count_item = 1'b1;
          if (stat.emit_ok) begin
            cmd.clr_acc = 1'b1;
            state_next = READ;
          end
        end
      end
      READ: begin
        cmd.rd_en = 1'b1;
        if (tap == 4'd8) state_next = ACC;
      end
      ACC: state_next = SQR;
      SQR: begin
        cmd.square = 1'b1;
        state_next = SUM;
      end
      SUM: begin
        cmd.sum = 1'b1;
        state_next = ROOT;
      end
      ROOT: begin
        cmd.root_step = 1'b1;
        if (bit_idx == 3'd0) state_next = RND;
      end
      RND: begin
        cmd.round = 1'b1;
        state_next = DONE;
      end
      DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // State, tap counter and root bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      tap <= '0;
      bit_idx <= 3'd7;
    end else begin
      state <= state_next;
      if (state == READ) tap <= tap + 4'd1;
      else tap <= '0;
      if (state == ROOT) bit_idx <= bit_idx - 3'd1;
      else bit_idx <= 3'd7;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (state == READ) |-> !s_tready) else $error("ready while busy");
  a_read_len: assert property (@(posedge clk) disable iff (rst)
    (state == ACC) |-> ($past(state) == READ && $past(tap) == 4'd8))
    else $error("window read cut short");
  a_root_len: assert property (@(posedge clk) disable iff (rst)
    (state == RND) |-> ($past(bit_idx) == 3'd0)) else $error("root steps short");

endmodule
`default_nettype wire

// ----- hdl/egm_datapath.sv -----
`default_nettype none
module egm_datapath
  import egm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic [3*PIX_W-1:0]     s_tdata,
  input  wire egm_cmd_t               cmd,
  output egm_stat_t                   stat,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [3*PIX_W-1:0]          m_tdata,
  output logic                        m_tlast
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(2 * MAX_WIDTH + 3);
  localparam int DEPTH = 1 << AW;

  logic [WREG_W-1:0] width_reg;
  logic [HREG_W-1:0] height_reg;
  logic [31:0]       w32;
  logic [31:0]       h32;
  logic [WW-1:0]     w;
  logic [CW-1:0]     wm1;
  logic [RW-1:0]     hm1;
  logic [AW-1:0]     w_a;

  logic [3*PIX_W-1:0] mem [DEPTH];
  logic [AW-1:0]      in_addr;
  logic [CW-1:0]      in_col;
  logic [RW-1:0]      in_row;
  logic               all_in;
  logic [WW:0]        lead;
  logic [AW-1:0]      out_addr;
  logic [CW-1:0]      out_col;
  logic [RW-1:0]      out_row;
  logic               out_last;
  logic               frame_clr;

  logic signed [1:0]  dr;
  logic signed [1:0]  dc;
  logic [AW-1:0]      rofs;
  logic [AW-1:0]      cofs;
  logic               row_ok;
  logic               col_ok;
  logic [3*PIX_W-1:0] rd_data;
  logic               rd_pend;
  logic signed [1:0]  rd_dr;
  logic signed [1:0]  rd_dc;

  logic signed [ACC_W-1:0] gx [3];
  logic signed [ACC_W-1:0] gy [3];
  logic [SQ_W-1:0]         sqx [3];
  logic [SQ_W-1:0]         sqy [3];
  logic [SUM_W-1:0]        ssum [3];
  logic [PIX_W-1:0]        root [3];

  // Effective frame size, saturated into the supported range.
  always_comb begin
    w32 = {{(32-WREG_W){1'b0}}, width_reg};
    h32 = {{(32-HREG_W){1'b0}}, height_reg};
    if (w32 == 32'd0) w32 = 32'd1;
    else if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    if (h32 == 32'd0) h32 = 32'd1;
    else if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    w = w32[WW-1:0];
    wm1 = CW'(w32 - 32'd1);
    hm1 = RW'(h32 - 32'd1);
    w_a = AW'(w32);
  end

  assign out_last = (out_row == hm1) && (out_col == wm1);
  assign frame_clr = cfg_wr_en || (cmd.load_out && out_last);
  assign stat.all_in = all_in;
  assign stat.emit_ok = (lead == ({1'b0, w} + 1'b1));
  assign stat.out_free = !m_tvalid || m_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= 11'd640;
      height_reg <= 13'd480;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_WIDTH) width_reg <= cfg_wdata[WREG_W-1:0];
      else if (cfg_addr == REG_HEIGHT) height_reg <= cfg_wdata[HREG_W-1:0];
    end
  end

  // Frame position counters for incoming pixels and outgoing results.
  always_ff @(posedge clk) begin
    if (rst || frame_clr) begin
      in_addr <= '0;
      in_col <= '0;
      in_row <= '0;
      all_in <= 1'b0;
      lead <= '0;
      out_addr <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (cmd.take_pixel) begin
        in_addr <= in_addr + 1'b1;
        if (in_col == wm1) begin
          in_col <= '0;
          if (in_row == hm1) all_in <= 1'b1;
          else in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.count_item && !stat.emit_ok) lead <= lead + 1'b1;
      if (cmd.load_out) begin
        out_addr <= out_addr + 1'b1;
        if (out_col == wm1) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // Pixel ring memory.
  always_ff @(posedge clk) begin
    if (cmd.take_pixel) mem[in_addr] <= s_tdata;
    if (cmd.rd_en) rd_data <= mem[out_addr + rofs + cofs];
  end

  // Window tap address and border mask.
  always_comb begin
    dr = tap_dr(cmd.tap);
    dc = tap_dc(cmd.tap);
    rofs = (dr == -2'sd1) ? (~w_a + 1'b1) : (dr == 2'sd1) ? w_a : '0;
    cofs = (dc == -2'sd1) ? '1 : (dc == 2'sd1) ? AW'(1) : '0;
    row_ok = (dr == -2'sd1) ? (out_row != '0) : (dr == 2'sd1) ? (out_row != hm1) : 1'b1;
    col_ok = (dc == -2'sd1) ? (out_col != '0) : (dc == 2'sd1) ? (out_col != wm1) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en && row_ok && col_ok;
    end
    rd_dr <= dr;
    rd_dc <= dc;
  end

  // Per channel gradient, square, iterative root and rounding.
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [ACC_W-1:0]   v;
    logic signed [2*ACC_W-1:0] px;
    logic signed [2*ACC_W-1:0] py;
    logic [PIX_W-1:0]          trial;
    logic [2*PIX_W-1:0]        tsq;
    logic [2*PIX_W-1:0]        rsq;
    logic [SUM_W-1:0]          rem;

    always_comb begin
      v = ACC_W'(rd_data[PIX_W*c +: PIX_W]);
      px = gx[c] * gx[c];
      py = gy[c] * gy[c];
      trial = root[c] | (PIX_W'(1) << cmd.root_bit);
      tsq = trial * trial;
      rsq = root[c] * root[c];
      rem = ssum[c] - SUM_W'(rsq);
    end

    always_ff @(posedge clk) begin
      if (cmd.clr_acc) begin
        gx[c] <= '0;
        gy[c] <= '0;
      end else if (rd_pend) begin
        if (rd_dc == 2'sd1) gx[c] <= gx[c] + v;
        else if (rd_dc == -2'sd1) gx[c] <= gx[c] - v;
        if (rd_dr == -2'sd1) gy[c] <= gy[c] + v;
        else if (rd_dr == 2'sd1) gy[c] <= gy[c] - v;
      end
      if (cmd.square) begin
        sqx[c] <= px[SQ_W-1:0];
        sqy[c] <= py[SQ_W-1:0];
      end
      if (cmd.sum) begin
        ssum[c] <= SUM_W'(sqx[c]) + SUM_W'(sqy[c]);
        root[c] <= '0;
      end else if (cmd.root_step) begin
        if (SUM_W'(tsq) <= ssum[c]) root[c] <= trial;
      end else if (cmd.round) begin
        if (ssum[c] > SAT_LIMIT) root[c] <= PIX_MAX;
        else if (rem > SUM_W'(root[c])) root[c] <= root[c] + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.load_out) begin
      m_tdata <= {root[2], root[1], root[0]};
      m_tlast <= out_last;
    end
  end

  a_store_order: assert property (@(posedge clk) disable iff (rst)
    cmd.take_pixel |-> !all_in) else $error("pixel stored after frame filled");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready)) else $error("result overwritten");
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && out_last) |=> (out_addr == '0 && lead == '0 && !all_in))
    else $error("frame counters not cleared");

endmodule
`default_nettype wire

// ----- hdl/edge_gradient_magnitude_rgb.sv -----
// Result for pixel p leaves after the item width+1 places later is accepted.
// An item that releases a result holds the input through acceptance, 9 window
// reads, accumulate, square, sum, 8 root steps, rounding and the output load;
// the load waits while the previous result is still held. Other items do not
// hold the input. Synchronous reset restores 640x480 and starts a new frame.
`default_nettype none
module edge_gradient_magnitude_rgb
  import egm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [3*PIX_W-1:0]   s_tdata,   // red_in, green_in, blue_in
  input  wire logic                 s_tuser,   // action
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [3*PIX_W-1:0]        m_tdata,   // red_edge, green_edge, blue_edge
  output logic                      m_tlast    // frame_end
);

  egm_cmd_t  cmd;
  egm_stat_t stat;

  egm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  egm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

// ----- verif/edge_gradient_magnitude_rgb_tb.sv -----
`default_nettype none
module edge_gradient_magnitude_rgb_tb;
  import egm_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 4096;
  localparam int RING = 2 * MAXW + 6;
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic       action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } edge_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_addr = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic m_tlast;

  edge_gradient_magnitude_rgb uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata),    // red_in, green_in, blue_in from the lowest bit up
    .s_tuser(s_tuser),    // action
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata),    // red_edge, green_edge, blue_edge from the lowest bit up
    .m_tlast(m_tlast)     // frame_end
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the pixel ring and frame counters.
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] pix_ring [RING];
  int unsigned taken_cnt;
  int unsigned emitted_cnt;

  pixel_req_t pending_reqs[$];
  edge_res_t expected_edges[$];
  int unsigned accepted_cnt = 0;
  int errors = 0;
  int cycles = 0;

  // Rounded square root of a sum of squares, saturated to 255.
  function automatic logic [7:0] grad_mag(input int gx, input int gy);
    int s;
    int r;
    s = gx * gx + gy * gy;
    if (s > 65280) return 8'd255;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s - r * r > r) r++;
    return r[7:0];
  endfunction

  function automatic int eff_w();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAXH) h = MAXH;
    return h;
  endfunction

  // Advance the prediction by one accepted request.
  task automatic predict_edges(input pixel_req_t req);
    int w, h, n, row, col, rr, cc, ch, v;
    int gx[3];
    int gy[3];
    edge_res_t res;
    w = eff_w();
    h = eff_h();
    n = w * h;
    if (taken_cnt < n) begin
      if (req.action == ACT_DRAIN) return;
      pix_ring[taken_cnt % RING] = {req.red, req.green, req.blue};
    end
    taken_cnt++;
    if (taken_cnt - 1 < w + 1 || emitted_cnt >= n) return;
    row = emitted_cnt / w;
    col = emitted_cnt % w;
    for (ch = 0; ch < 3; ch++) begin
      gx[ch] = 0;
      gy[ch] = 0;
    end
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = row + dr;
        cc = col + dc;
        if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
          for (ch = 0; ch < 3; ch++) begin
            v = pix_ring[(rr * w + cc) % RING][23 - 8 * ch -: 8];
            gx[ch] += dc * v;
            gy[ch] -= dr * v;
          end
        end
      end
    end
    res.red = grad_mag(gx[0], gy[0]);
    res.green = grad_mag(gx[1], gy[1]);
    res.blue = grad_mag(gx[2], gy[2]);
    res.frame_end = (emitted_cnt == n - 1);
    expected_edges.push_back(res);
    emitted_cnt++;
    if (res.frame_end) begin
      taken_cnt = 0;
      emitted_cnt = 0;
    end
  endtask

  // Short gaps are common, long ones rare.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Set at a rising edge on which a request was accepted.
  logic s_tready_q = 1'b0;

  // Driver: presents queued requests with random gaps.
  int drv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready_q) begin
        void'(pending_reqs.pop_front());
        drv_gap = pick_gap();
      end
      if (drv_gap > 0) begin
        drv_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_reqs[0].action;
        s_tdata <= {pending_reqs[0].blue, pending_reqs[0].green, pending_reqs[0].red};
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: predicts on accepted requests and checks accepted results.
  always @(posedge clk) begin
    edge_res_t got;
    edge_res_t want;
    cycles++;
    s_tready_q <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_edges(pending_reqs[0]);
      accepted_cnt++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_edges.pop_front();
        if (got !== want)
          $display({"%0t: edge mismatch, expected r%0d g%0d b%0d last%0d,",
                    " actual r%0d g%0d b%0d last%0d"},
                   $time, want.red, want.green, want.blue, want.frame_end,
                   got.red, got.green, got.blue, got.frame_end);
        if (got !== want) errors++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Register write between frames; the predictor follows.
  task automatic write_reg(input logic idx, input int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_WIDTH) width_reg = value[10:0];
    else height_reg = value[12:0];
    taken_cnt = 0;
    emitted_cnt = 0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_edges.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic pixel_req_t rand_pixel();
    pixel_req_t p;
    p.action = ACT_PIXEL;
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    return p;
  endfunction

  // One frame of pixels, drains to flush it, with some stray noise items.
  task automatic queue_frame(input int w, input int h, input bit noisy);
    pixel_req_t p;
    int n;
    n = (w < 1 ? 1 : (w > MAXW ? MAXW : w)) * (h < 1 ? 1 : (h > MAXH ? MAXH : h));
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        p = rand_pixel();
        p.action = ACT_DRAIN;
        pending_reqs.push_back(p);
      end
      p = rand_pixel();
      if ($urandom_range(0, 7) == 0) p.red = {8{p.red[0]}};
      pending_reqs.push_back(p);
    end
    for (int i = 0; i < (w < 1 ? 1 : (w > MAXW ? MAXW : w)) + 1; i++) begin
      p = noisy && $urandom_range(0, 3) == 0 ? rand_pixel() : '0;
      p.action = noisy && $urandom_range(0, 3) == 0 ? ACT_PIXEL : ACT_DRAIN;
      p.blue = 8'($urandom);
      pending_reqs.push_back(p);
    end
  endtask

  initial begin
    int w, h;
    pixel_req_t p;
    width_reg = 11'd640;
    height_reg = 13'd480;
    taken_cnt = 0;
    emitted_cnt = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: tiny frames, field extremes, borders and corner padding.
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    p = '0;
    for (int i = 0; i < 9; i++) begin
      p.red = (i % 2) ? 8'hFF : 8'h00;
      p.green = 8'hFF;
      p.blue = (i == 4) ? 8'hFF : 8'h00;
      pending_reqs.push_back(p);
    end
    p = '1;
    pending_reqs.push_back(p);
    p.action = ACT_DRAIN;
    repeat (3) pending_reqs.push_back(p);
    wait_idle();
    // Out-of-range registers saturate: zero means one.
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    queue_frame(0, 0, 1'b1);
    wait_idle();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 8191);
    queue_frame(1, 8191 > 20 ? 20 : 1, 1'b0);
    wait_idle();

    // Random frames, mostly small.
    while (accepted_cnt < 1200) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      if (w * h > 300) h = 2;
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      queue_frame(w, h, 1'b1);
      wait_idle();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
